// File: src/kda_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the key debounce / autorepeat core.
// No dependencies.
package kda_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int IN_TDATA_W       = 8;
  localparam int OUT_TDATA_W      = 8;

  localparam logic [CFG_W-1:0] PERIOD_DEF   = 16'd20;
  localparam logic [CFG_W-1:0] DELAY_DEF    = 16'd150;
  localparam logic [CFG_W-1:0] DEBOUNCE_DEF = 16'd15;
  localparam logic [CFG_W-1:0] CONFIRM_DEF  = 16'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD   = 2'd0,
    REG_DELAY    = 2'd1,
    REG_DEBOUNCE = 2'd2,
    REG_CONFIRM  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DEBOUNCE  = 3'd1,
    PH_CONFIRMED = 3'd2,
    PH_WAITREP   = 3'd3,
    PH_REPEAT    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] repeat_period;
    logic [CFG_W-1:0] repeat_delay;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] confirm_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] key_phase;
    logic       repeat_event;
    logic       push_event;
  } res_t;

endpackage

// File: src/key_debounce_autorepeat_core.sv
`timescale 1ns / 1ps
// Key debounce with autorepeat, stream in / stream out, one result per request.
// Result valid at the output register in the cycle after request accept.
// Throughput: 1 request per cycle; in_tready drops only while a result waits
// and out_tready is low. Synchronous active-low reset: phase idle, counter zero,
// output empty, registers 20 / 150 / 15 / 5. Depends on kda_pkg and submodules.
module key_debounce_autorepeat_core #(
  parameter int COUNTER_BITS = kda_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kda_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] pin_level
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kda_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] push_event, [1] repeat_event,
                                                      // [4:2] key_phase
  input  logic                            cfg_we,
  input  logic [kda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kda_pkg::CFG_W-1:0]       cfg_wdata
);

  kda_pkg::cfg_t cfg;
  kda_pkg::res_t step_res, buf_res;
  logic          accept, can_load;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  kda_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  kda_step #(.COUNTER_BITS(COUNTER_BITS)) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (accept),
    .pin_level (in_tdata[0]),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  kda_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res_i      (step_res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_o      (buf_res)
  );

  assign out_tdata = {3'b000, buf_res};

endmodule

// File: src/kda_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank: four 16-bit registers, write only.
// Depends on kda_pkg.
module kda_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kda_pkg::CFG_W-1:0]     cfg_wdata,
  output kda_pkg::cfg_t                 cfg_o
);

  kda_pkg::cfg_t cfg_r;
  kda_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (kda_pkg::reg_idx_t'(cfg_index))
        kda_pkg::REG_PERIOD:   cfg_nxt.repeat_period  = cfg_wdata;
        kda_pkg::REG_DELAY:    cfg_nxt.repeat_delay   = cfg_wdata;
        kda_pkg::REG_DEBOUNCE: cfg_nxt.debounce_ticks = cfg_wdata;
        kda_pkg::REG_CONFIRM:  cfg_nxt.confirm_ticks  = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_period  <= kda_pkg::PERIOD_DEF;
      cfg_r.repeat_delay   <= kda_pkg::DELAY_DEF;
      cfg_r.debounce_ticks <= kda_pkg::DEBOUNCE_DEF;
      cfg_r.confirm_ticks  <= kda_pkg::CONFIRM_DEF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: src/kda_step.sv
`timescale 1ns / 1ps
// Phase machine and shared down-counter; one step per accepted request.
// Depends on kda_pkg.
module kda_step #(
  parameter int COUNTER_BITS = kda_pkg::COUNTER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          pin_level,
  input  kda_pkg::cfg_t cfg_i,
  output kda_pkg::res_t res_o
);

  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNTER_BITS) - 64'd1);

  function automatic logic [COUNTER_BITS-1:0] clamp_load(
    input logic [kda_pkg::CFG_W-1:0] v
  );
    logic [31:0] ext;
    ext = 32'(v);
    if (ext > CNT_MAX) return CNT_MAX[COUNTER_BITS-1:0];
    else return ext[COUNTER_BITS-1:0];
  endfunction

  kda_pkg::phase_t         phase_r, phase_nxt, phase_a;
  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt, cnt_a;
  logic                    pressed, zero, push, rep;
  logic [kda_pkg::CFG_W-1:0] period, delay;

  assign pressed = ~pin_level;
  assign zero    = (cnt_r == '0);
  assign period  = (cfg_i.repeat_period == '0) ? kda_pkg::PERIOD_DEF : cfg_i.repeat_period;
  assign delay   = (cfg_i.repeat_delay == '0) ? kda_pkg::DELAY_DEF : cfg_i.repeat_delay;

  // next state
  always_comb begin
    phase_a = phase_r;
    cnt_a   = cnt_r;
    push    = 1'b0;
    rep     = 1'b0;
    priority if (pressed && phase_r == kda_pkg::PH_IDLE) begin
      phase_a = kda_pkg::PH_DEBOUNCE;
      cnt_a   = clamp_load(cfg_i.debounce_ticks);
    end else if (phase_r != kda_pkg::PH_IDLE) begin
      priority if (pressed && phase_r == kda_pkg::PH_DEBOUNCE && zero) begin
        phase_a = kda_pkg::PH_CONFIRMED;
        cnt_a   = clamp_load(cfg_i.confirm_ticks);
      end else if (!pressed && (phase_r == kda_pkg::PH_CONFIRMED ||
                                phase_r == kda_pkg::PH_WAITREP)) begin
        push    = 1'b1;
        phase_a = kda_pkg::PH_IDLE;
      end else if (pressed && phase_r == kda_pkg::PH_CONFIRMED && zero) begin
        phase_a = kda_pkg::PH_WAITREP;
        cnt_a   = clamp_load(delay);
      end else if (pressed && phase_r == kda_pkg::PH_WAITREP && zero) begin
        phase_a = kda_pkg::PH_REPEAT;
      end else if (pressed && phase_r == kda_pkg::PH_REPEAT && zero) begin
        cnt_a = clamp_load(period);
        rep   = 1'b1;
      end else begin
        phase_a = phase_r;
      end
    end else begin
      phase_a = kda_pkg::PH_IDLE;
    end
    phase_nxt = phase_a;
    if (!pressed && (3'(phase_a) >= 3'(kda_pkg::PH_WAITREP))) begin
      phase_nxt = kda_pkg::PH_IDLE;
    end
    cnt_nxt = (cnt_a != '0) ? cnt_a - COUNTER_BITS'(1) : '0;
  end

  // outputs
  always_comb begin
    res_o.push_event   = push;
    res_o.repeat_event = rep;
    res_o.key_phase    = 3'(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kda_pkg::PH_IDLE;
      cnt_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_rep_only_repeating: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && rep |-> phase_r == kda_pkg::PH_REPEAT)
    else $error("repeat event outside repeating phase");

  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && push |-> (phase_r == kda_pkg::PH_CONFIRMED || phase_r == kda_pkg::PH_WAITREP))
    else $error("push event from wrong phase");

  a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && pin_level &&
    (phase_r == kda_pkg::PH_WAITREP || phase_r == kda_pkg::PH_REPEAT)
    |=> phase_r == kda_pkg::PH_IDLE)
    else $error("release did not return to idle");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(cnt_r))
    else $error("state moved without a request");

endmodule

// File: src/kda_outbuf.sv
`timescale 1ns / 1ps
// Result register between the step logic and the output stream.
// Depends on kda_pkg.
module kda_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  kda_pkg::res_t res_i,
  output logic          can_load,
  output logic          out_tvalid,
  input  logic          out_tready,
  output kda_pkg::res_t res_o
);

  logic          valid_r, valid_nxt;
  kda_pkg::res_t data_r;

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= res_i;
  end

  assign out_tvalid = valid_r;
  assign res_o      = data_r;

endmodule

// File: test/key_report_checker.sv
`timescale 1ns / 1ps
// Checker for key_debounce_autorepeat_core: tracks register writes, predicts one key
// report per accepted tick and compares it with the output stream. Depends on kda_pkg.
module key_report_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [kda_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] pin_level
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [kda_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] push_event, [1] repeat_event,
                                                      // [4:2] key_phase
  input  logic                            cfg_we,
  input  logic [kda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kda_pkg::CFG_W-1:0]       cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              push_seen,
  output int                              repeat_seen
);
  import kda_pkg::*;

  cfg_t                          regs;
  phase_t                        key_phase;
  logic [COUNTER_BITS_DEF-1:0]   tick_cnt;
  res_t                          key_reports_q[$];

  function automatic res_t step_key(logic pin);
    logic pressed;
    logic zero;
    logic [CFG_W-1:0] per;
    logic [CFG_W-1:0] dly;
    res_t r;
    pressed = !pin;
    zero    = (tick_cnt == '0);
    per     = (regs.repeat_period != '0) ? regs.repeat_period : PERIOD_DEF;
    dly     = (regs.repeat_delay != '0) ? regs.repeat_delay : DELAY_DEF;
    r       = '0;
    if (pressed && key_phase == PH_IDLE) begin
      key_phase = PH_DEBOUNCE;
      tick_cnt  = regs.debounce_ticks;
    end else if (key_phase != PH_IDLE) begin
      if (pressed && key_phase == PH_DEBOUNCE && zero) begin
        key_phase = PH_CONFIRMED;
        tick_cnt  = regs.confirm_ticks;
      end else if (!pressed && (key_phase == PH_CONFIRMED || key_phase == PH_WAITREP)) begin
        r.push_event = 1'b1;
        key_phase    = PH_IDLE;
      end else if (pressed && key_phase == PH_CONFIRMED && zero) begin
        key_phase = PH_WAITREP;
        tick_cnt  = dly;
      end else if (pressed && key_phase == PH_WAITREP && zero) begin
        key_phase = PH_REPEAT;
      end else if (pressed && key_phase == PH_REPEAT && zero) begin
        tick_cnt       = per;
        r.repeat_event = 1'b1;
      end
    end
    // drop back to idle on release from the upper phases
    if (key_phase >= PH_WAITREP && !pressed) key_phase = PH_IDLE;
    if (tick_cnt != '0) tick_cnt = tick_cnt - COUNTER_BITS_DEF'(1);
    r.key_phase = key_phase;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      regs.repeat_period  <= PERIOD_DEF;
      regs.repeat_delay   <= DELAY_DEF;
      regs.debounce_ticks <= DEBOUNCE_DEF;
      regs.confirm_ticks  <= CONFIRM_DEF;
      key_phase   = PH_IDLE;
      tick_cnt    = '0;
      key_reports_q.delete();
      fail_count  = 0;
      checked     = 0;
      push_seen   = 0;
      repeat_seen = 0;
      pending     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        if (key_reports_q.size() == 0) begin
          $error("unexpected key report %b with nothing pending", got);
          fail_count++;
        end else begin
          want = key_reports_q.pop_front();
          checked++;
          if (got.push_event) push_seen++;
          if (got.repeat_event) repeat_seen++;
          if (got.push_event !== want.push_event) begin
            $error("push_event: expected %b, got %b", want.push_event, got.push_event);
            fail_count++;
          end
          if (got.repeat_event !== want.repeat_event) begin
            $error("repeat_event: expected %b, got %b", want.repeat_event, got.repeat_event);
            fail_count++;
          end
          if (got.key_phase !== want.key_phase) begin
            $error("key_phase: expected %0d, got %0d", want.key_phase, got.key_phase);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) key_reports_q.push_back(step_key(in_tdata[0]));
      pending = key_reports_q.size();
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PERIOD:   regs.repeat_period  <= cfg_wdata;
          REG_DELAY:    regs.repeat_delay   <= cfg_wdata;
          REG_DEBOUNCE: regs.debounce_ticks <= cfg_wdata;
          REG_CONFIRM:  regs.confirm_ticks  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: test/tb_key_debounce_autorepeat_core.sv
`timescale 1ns / 1ps
// Testbench top for key_debounce_autorepeat_core: drives key ticks and register writes
// under random back-pressure and reports the verdict. Depends on kda_pkg, key_report_checker.
module tb_key_debounce_autorepeat_core;
  import kda_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [0] pin_level
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [0] push_event, [1] repeat_event, [4:2] key_phase
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  int fail_count, pending, checked, push_seen, repeat_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  bit hold_req      = 1'b0;

  always #5 clk = ~clk;

  key_debounce_autorepeat_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  key_report_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .push_seen   (push_seen),
    .repeat_seen (repeat_seen)
  );

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_cnt = 60;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** key_debounce_autorepeat_core: FAILED **");
    $finish;
  end

  task automatic send_pin(logic pin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, pin};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // send only while the budget of the current setting lasts
  task automatic send_within(logic pin, int stop);
    if (items_sent < stop) send_pin(pin);
  endtask

  task automatic load_regs(logic [CFG_W-1:0] per, logic [CFG_W-1:0] dly,
                           logic [CFG_W-1:0] deb, logic [CFG_W-1:0] cnf);
    reg_idx_t         order [4];
    logic [CFG_W-1:0] vals  [4];
    order = '{REG_PERIOD, REG_DELAY, REG_DEBOUNCE, REG_CONFIRM};
    vals  = '{per, dly, deb, cnf};
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin send_idle_pct = 24; recv_idle_pct = 53; end
      1: begin send_idle_pct = 53; recv_idle_pct = 24; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // mostly clean presses of random length, some with bounce, some pure noise
  task automatic play_keys(int budget, logic [CFG_W-1:0] per, logic [CFG_W-1:0] dly,
                           logic [CFG_W-1:0] deb, logic [CFG_W-1:0] cnf);
    int stop;
    int span;
    int p;
    int d;
    stop = items_sent + budget;
    p    = (per == '0) ? 20 : ((per > 100) ? 100 : int'(per));
    d    = (dly == '0) ? 150 : ((dly > 200) ? 200 : int'(dly));
    span = ((deb > 100) ? 100 : int'(deb)) + ((cnf > 100) ? 100 : int'(cnf)) + d + 3 * p + 4;
    if (span > 400) span = 400;
    while (items_sent < stop) begin
      repeat ($urandom_range(1, 6)) send_within(1'b1, stop);
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 6)) send_within(1'($urandom_range(1)), stop);
        1, 2: begin
          repeat ($urandom_range(1, 3)) begin
            send_within(1'b0, stop);
            send_within(1'b1, stop);
          end
          repeat ($urandom_range(1, span)) send_within(1'b0, stop);
        end
        default: repeat ($urandom_range(1, span)) send_within(1'b0, stop);
      endcase
    end
  endtask

  initial begin
    logic [24:0]      directed;
    logic [CFG_W-1:0] per, dly, deb, cnf;
    int               budget;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short timing: bounce in debounce, confirm via a late press, repeats, push,
    // release from repeating
    set_idle(0);
    load_regs(16'd1, 16'd2, 16'd2, 16'd1);
    directed = 25'b1_0000_0110_0001_1000_0000_0101;
    for (int i = 0; i < 25; i++) send_pin(directed[i]);

    for (int k = 0; k < 9; k++) begin
      budget = 128;
      case (k)
        0: begin per = PERIOD_DEF; dly = DELAY_DEF; deb = DEBOUNCE_DEF; cnf = CONFIRM_DEF; end
        1: begin per = 16'd0; dly = 16'd0; deb = 16'd0; cnf = 16'd0; end
        2: begin per = 16'd1; dly = 16'd1; deb = 16'd1; cnf = 16'd1; end
        3: begin per = 16'hFFFF; dly = 16'd3; deb = 16'd2; cnf = 16'hFFFF; end
        8: begin per = 16'd7; dly = 16'hFFFF; deb = 16'hFFFF; cnf = 16'd0; budget = 60; end
        default: begin
          per = CFG_W'($urandom_range(0, 9));
          dly = CFG_W'($urandom_range(0, 12));
          deb = CFG_W'($urandom_range(0, 8));
          cnf = CFG_W'($urandom_range(0, 8));
        end
      endcase
      set_idle(k / 3);
      load_regs(per, dly, deb, cnf);
      if (k == 4) hold_req = 1'b1;
      play_keys(budget, per, dly, deb, cnf);
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Sent %0d key ticks over ten register settings; %0d reports checked,",
             items_sent, checked);
    $display("with %0d push and %0d repeat events seen.", push_seen, repeat_seen);
    if (fail_count == 0) begin
      $display("** key_debounce_autorepeat_core: PASSED **");
    end else begin
      $display("** key_debounce_autorepeat_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
src/kda_pkg.sv
src/kda_cfg.sv
src/kda_step.sv
src/kda_outbuf.sv
src/key_debounce_autorepeat_core.sv
test/key_report_checker.sv
test/tb_key_debounce_autorepeat_core.sv
